@@ sv/fmp_pkg.sv @@
package fmp_pkg;

    // word width of every matrix entry and of the result
    localparam int RESULT_WIDTH = 32;
    // width of the requested index
    localparam int INDEX_BITS = 31;

    typedef logic [RESULT_WIDTH-1:0] t_word;
    typedef logic [INDEX_BITS-1:0]   t_index;

    // sequencer step within one matrix product
    typedef logic [1:0] t_step;

    // last step of a general product and of a squaring
    localparam t_step MUL_LAST = 2'd3;
    localparam t_step SQR_LAST = 2'd2;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic load;    // start both sums with the product
        logic add_e10; // add the product to the lower-left sum
        logic add_e11; // add the product to the lower-right sum
        logic dbl;     // add twice the product
    } t_mac_ctl;

endpackage

@@ sv/fibonacci_matrix_power.sv @@
// Fibonacci number F(n) modulo 2^32 by square-and-multiply of [[1,1],[1,0]].
//
// Input channel: i_valid / o_ready with i_index_n (31 bits). Output channel:
// o_valid / i_ready with o_fib_value (32 bits). A transfer happens on a
// rising edge where valid and ready are both high.
//
// Every power of the base is held as the pair (F(k), F(k-1)), so a product
// of two powers costs four multiplies and a squaring three, all on one
// shared 32x32 multiplier with two accumulators. Index bits are scanned
// from the least significant upward and the scan stops at the highest set
// bit; the final squaring is skipped.
// One index is worked on at a time: o_ready is high only while the block is
// idle, so a new index is taken only after the last result is transferred.
// The result stays on o_fib_value with o_valid high until i_ready takes it;
// no new index is accepted in that time.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_valid; a result in flight is discarded.
module fibonacci_matrix_power (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  fmp_pkg::t_index       i_index_n,
    output logic                  o_valid,
    input  logic                  i_ready,
    output fmp_pkg::t_word        o_fib_value
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_SQR  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    fmp_pkg::t_step    r_step;
    fmp_pkg::t_step    n_step;
    fmp_pkg::t_index   r_n;
    fmp_pkg::t_index   n_n;

    // result power (F(k), F(k-1)) and base power
    fmp_pkg::t_word    r_acc_b;
    fmp_pkg::t_word    r_acc_a;
    fmp_pkg::t_word    r_base_b;
    fmp_pkg::t_word    r_base_a;
    fmp_pkg::t_word    n_acc_b;
    fmp_pkg::t_word    n_acc_a;
    fmp_pkg::t_word    n_base_b;
    fmp_pkg::t_word    n_base_a;

    fmp_pkg::t_word    w_x;
    fmp_pkg::t_word    w_y;
    fmp_pkg::t_mac_ctl w_ctl;
    fmp_pkg::t_word    w_e10;
    fmp_pkg::t_word    w_n_e11;
    fmp_pkg::t_index   w_n_shr;

    assign w_n_shr = r_n >> 1;

    // shared multiply-accumulate unit
    fmp_mac u_mac (
        .i_clk   (i_clk),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_ctl   (w_ctl),
        .o_e10   (w_e10),
        .o_n_e11 (w_n_e11)
    );

    // operand selection and unit control per step
    always_comb begin
        w_x   = r_acc_b;
        w_y   = r_base_b;
        w_ctl = '0;
        unique case (r_state)
            S_MUL: begin
                case (r_step)
                    2'd0: begin
                        w_x = r_acc_b;
                        w_y = r_base_b;
                        w_ctl.load = 1'b1;
                    end
                    2'd1: begin
                        w_x = r_acc_b;
                        w_y = r_base_a;
                        w_ctl.add_e10 = 1'b1;
                    end
                    2'd2: begin
                        w_x = r_acc_a;
                        w_y = r_base_b;
                        w_ctl.add_e10 = 1'b1;
                    end
                    default: begin
                        w_x = r_acc_a;
                        w_y = r_base_a;
                        w_ctl.add_e11 = 1'b1;
                    end
                endcase
            end
            S_SQR: begin
                case (r_step)
                    2'd0: begin
                        w_x = r_base_b;
                        w_y = r_base_b;
                        w_ctl.load = 1'b1;
                    end
                    2'd1: begin
                        w_x = r_base_a;
                        w_y = r_base_b;
                        w_ctl.add_e10 = 1'b1;
                        w_ctl.dbl     = 1'b1;
                    end
                    default: begin
                        w_x = r_base_a;
                        w_y = r_base_a;
                        w_ctl.add_e11 = 1'b1;
                    end
                endcase
            end
            S_IDLE, S_DONE: begin
                w_ctl = '0;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_n      = r_n;
        n_acc_b  = r_acc_b;
        n_acc_a  = r_acc_a;
        n_base_b = r_base_b;
        n_base_a = r_base_a;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_n      = i_index_n;
                    n_step   = '0;
                    n_acc_b  = fmp_pkg::t_word'(0);
                    n_acc_a  = fmp_pkg::t_word'(1);
                    n_base_b = fmp_pkg::t_word'(1);
                    n_base_a = fmp_pkg::t_word'(0);
                    if (i_index_n == '0) begin
                        n_state = S_DONE;
                    end else if (i_index_n[0]) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_SQR;
                    end
                end
            end
            S_MUL: begin
                n_step = r_step + 2'd1;
                if (r_step == fmp_pkg::MUL_LAST) begin
                    n_acc_b = w_e10;
                    n_acc_a = w_n_e11;
                    n_step  = '0;
                    // no higher bit left: the last squaring is not needed
                    n_state = (w_n_shr == '0) ? S_DONE : S_SQR;
                end
            end
            S_SQR: begin
                n_step = r_step + 2'd1;
                if (r_step == fmp_pkg::SQR_LAST) begin
                    n_base_b = w_e10;
                    n_base_a = w_n_e11;
                    n_step   = '0;
                    n_n      = w_n_shr;
                    if (w_n_shr == '0) begin
                        n_state = S_DONE;
                    end else if (w_n_shr[0]) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_SQR;
                    end
                end
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_acc_b  <= n_acc_b;
        r_acc_a  <= n_acc_a;
        r_base_b <= n_base_b;
        r_base_a <= n_base_a;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_DONE);
    assign o_fib_value = r_acc_b;

endmodule

@@ sv/fmp_mac.sv @@
module fmp_mac (
    input  logic              i_clk,
    input  fmp_pkg::t_word    i_x,
    input  fmp_pkg::t_word    i_y,
    input  fmp_pkg::t_mac_ctl i_ctl,
    output fmp_pkg::t_word    o_e10,
    output fmp_pkg::t_word    o_n_e11
);

    fmp_pkg::t_word w_prod;
    fmp_pkg::t_word w_addend;
    fmp_pkg::t_word r_e10;
    fmp_pkg::t_word r_e11;
    fmp_pkg::t_word n_e10;
    fmp_pkg::t_word n_e11;

    // single wrapping multiplier, low word only
    assign w_prod   = i_x * i_y;
    assign w_addend = i_ctl.dbl ? (w_prod << 1) : w_prod;

    // next values of the two running sums
    always_comb begin
        n_e10 = r_e10;
        n_e11 = r_e11;
        if (i_ctl.load) begin
            n_e10 = w_prod;
            n_e11 = w_prod;
        end else begin
            if (i_ctl.add_e10) begin
                n_e10 = r_e10 + w_addend;
            end
            if (i_ctl.add_e11) begin
                n_e11 = r_e11 + w_addend;
            end
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        r_e10 <= n_e10;
        r_e11 <= n_e11;
    end

    assign o_e10   = r_e10;
    assign o_n_e11 = n_e11;

endmodule

@@ test/fmp_checker.sv @@
module fmp_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  fmp_pkg::t_index i_index_n,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  fmp_pkg::t_word  i_fib_value,
    output int              o_fail_count,
    output int              o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // 2x2 matrix of wrapping words, row-major
    typedef struct packed {
        fmp_pkg::t_word e00;
        fmp_pkg::t_word e01;
        fmp_pkg::t_word e10;
        fmp_pkg::t_word e11;
    } t_mat2;

    // one outstanding term: the index asked for and its value
    typedef struct packed {
        fmp_pkg::t_index index_n;
        fmp_pkg::t_word  fib_value;
    } t_fib_term;

    t_fib_term fib_terms_due[$];
    int        mismatch_total = 0;

    assign o_fail_count    = mismatch_total;
    assign o_pending_count = fib_terms_due.size();

    // matrix product, every sum and product wrapping at the word width
    function automatic t_mat2 mat2_product(input t_mat2 a, input t_mat2 b);
        t_mat2 p;
        p.e00 = a.e00 * b.e00 + a.e01 * b.e10;
        p.e01 = a.e00 * b.e01 + a.e01 * b.e11;
        p.e10 = a.e10 * b.e00 + a.e11 * b.e10;
        p.e11 = a.e10 * b.e01 + a.e11 * b.e11;
        return p;
    endfunction

    // F(n) by square-and-multiply, scanning index bits from the bottom
    function automatic fmp_pkg::t_word fib_of_index(input fmp_pkg::t_index n);
        t_mat2           power;
        t_mat2           running;
        fmp_pkg::t_index rest;
        power   = '{e00: 1, e01: 1, e10: 1, e11: 0};
        running = '{e00: 1, e01: 0, e10: 0, e11: 1};
        rest    = n;
        while (rest != '0) begin
            if (rest[0]) begin
                running = mat2_product(running, power);
            end
            power = mat2_product(power, power);
            rest  = rest >> 1;
        end
        return running.e10;
    endfunction

    // result transfer checked before any index transfer at the same edge
    always @(posedge i_clk) begin
        t_fib_term due;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (fib_terms_due.size() == 0) begin
                    $error("fib_value: unexpected result %0h with nothing outstanding",
                           i_fib_value);
                    mismatch_total++;
                end else begin
                    due = fib_terms_due.pop_front();
                    if (i_fib_value !== due.fib_value) begin
                        $error("fib_value (index %0d): expected %0h, actual %0h",
                               due.index_n, due.fib_value, i_fib_value);
                        mismatch_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                fib_terms_due.push_back('{index_n: i_index_n,
                                          fib_value: fib_of_index(i_index_n)});
            end
        end
    end

endmodule

@@ test/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 1000;
    localparam int DRAIN_CYCLES  = 240;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 2_000_000;

    logic            i_clk     = 1'b0;
    logic            i_rst_n   = 1'b0;
    logic            i_valid   = 1'b0;
    logic            o_ready;
    fmp_pkg::t_index i_index_n = '0;
    logic            o_valid;
    logic            i_ready   = 1'b0;
    fmp_pkg::t_word  o_fib_value;

    int fail_count;
    int pending_count;
    int tx_idle_pct  = 20;
    int rx_idle_pct  = 54;
    bit hold_request = 1'b0;
    int cycle_count  = 0;

    fibonacci_matrix_power dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_index_n  (i_index_n),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_fib_value(o_fib_value)
    );

    fmp_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_index_n      (i_index_n),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_fib_value    (o_fib_value),
        .o_fail_count   (fail_count),
        .o_pending_count(pending_count)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // offer one index, with a random gap first, until its transfer
    task automatic offer_index(input fmp_pkg::t_index n);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_index_n <= n;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // random index: full range, small terms around the wrap, or random bit length
    function automatic fmp_pkg::t_index random_index();
        int unsigned bit_len;
        case ($urandom_range(0, 3))
            0, 1: return fmp_pkg::t_index'($urandom);
            2: return fmp_pkg::t_index'($urandom_range(0, 120));
            default: begin
                bit_len = $urandom_range(1, fmp_pkg::INDEX_BITS);
                return fmp_pkg::t_index'($urandom & ((32'h1 << bit_len) - 1));
            end
        endcase
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !held) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // reset, directed indices, then random indices in three idling phases
    initial begin
        fmp_pkg::t_index directed_indices[$];
        directed_indices = '{
            0, 1, 2, 3, 4, 5, 10, 31, 46, 47, 48, 63, 64, 93, 94, 100, 1000,
            31'h0001_0000, 31'h4000_0000, 31'h7fff_ffff, 31'h5555_5555,
            31'h2aaa_aaaa, 31'h3fff_ffff, 31'd12345678
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_indices[k]) begin
            offer_index(directed_indices[k]);
        end

        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            if (item == RANDOM_ITEMS / 3) begin
                tx_idle_pct = 54;
                rx_idle_pct = 20;
            end else if (item == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct  = 0;
                rx_idle_pct  = 0;
                hold_request = 1'b1;
            end
            offer_index(random_index());
        end
        i_valid <= 1'b0;

        // wait for every outstanding term, then let stray results show up
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/fmp_pkg.sv
sv/fmp_mac.sv
sv/fibonacci_matrix_power.sv
test/fmp_checker.sv
test/testbench.sv
